// ----- sv/nkro_keyboard_report_engine_macros.svh -----
// assertion helpers for the nkro report engine
`ifndef NKRO_KEYBOARD_REPORT_ENGINE_MACROS_SVH
`define NKRO_KEYBOARD_REPORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NKRO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NKRO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NKRO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define NKRO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- sv/nkro_pkg.sv -----
`default_nettype none

package nkro_pkg;

  localparam int unsigned REPORT_BYTES_DEF   = 32;
  localparam int unsigned BOOT_KEY_SLOTS_DEF = 6;

  localparam int unsigned OPC_W  = 3;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 5;

  // first modifier usage code, modifiers occupy eight codes from here
  localparam logic [KEY_W-1:0] MOD_FIRST = 8'hE0;

  typedef enum logic [OPC_W-1:0] {
    OP_KEY_DOWN    = 3'd0,
    OP_KEY_UP      = 3'd1,
    OP_RELEASE_ALL = 3'd2,
    OP_SEND        = 3'd3,
    OP_SEND_CHG    = 3'd4
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic key_wr;
    logic key_set;
    logic clear_all;
    logic start;
    logic scan;
    logic emit;
    logic boot;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic emit_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/nkro_dpath.sv -----
`default_nettype none
`include "nkro_keyboard_report_engine_macros.svh"

module nkro_dpath
  import nkro_pkg::*;
#(
  parameter int unsigned REPORT_BYTES   = REPORT_BYTES_DEF,
  parameter int unsigned BOOT_KEY_SLOTS = BOOT_KEY_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire logic [KEY_W-1:0]  in_keycode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_report_byte,
  output logic [IDX_W-1:0]       out_byte_index,
  output logic                   out_last_byte
);

  localparam int unsigned BI_W  = $clog2(REPORT_BYTES);
  localparam int unsigned SL_W  = (BOOT_KEY_SLOTS > 1) ? $clog2(BOOT_KEY_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(BOOT_KEY_SLOTS + 2);

  logic [BYTE_W-1:0] bmp_r [REPORT_BYTES];

  logic              is_mod;
  logic [5:0]        key_byte;
  logic              key_in_map;

  logic [BI_W-1:0]   rd_addr;
  logic [BYTE_W-1:0] rd_byte;

  logic [BI_W-1:0]   scan_idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [BYTE_W-1:0] slots_r   [BOOT_KEY_SLOTS];
  logic [BYTE_W-1:0] slots_nxt [BOOT_KEY_SLOTS];
  logic [KEY_W-1:0]  code_base;

  logic [IDX_W-1:0]  emit_idx_r;
  logic [IDX_W-1:0]  slot_sel;
  logic              overflow;
  logic [BYTE_W-1:0] slot_byte;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              load;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  // key address decode
  assign is_mod     = (in_keycode[7:3] == MOD_FIRST[7:3]);
  assign key_byte   = is_mod ? 6'd0 : ({1'b0, in_keycode[7:3]} + 6'd1);
  assign key_in_map = (key_byte < 6'(REPORT_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < int'(REPORT_BYTES); j++) bmp_r[j] <= '0;
    end else if (cmd.clear_all) begin
      for (int j = 0; j < int'(REPORT_BYTES); j++) bmp_r[j] <= '0;
    end else if (cmd.key_wr && key_in_map) begin
      for (int j = 0; j < int'(REPORT_BYTES); j++) begin
        if (key_byte == 6'(j)) bmp_r[j][in_keycode[2:0]] <= cmd.key_set;
      end
    end
  end

  // single read port shared by scan and emit
  assign rd_addr = cmd.scan ? scan_idx_r : emit_idx_r[BI_W-1:0];
  assign rd_byte = bmp_r[rd_addr];

  // one bitmap byte per cycle into the slot list
  always_comb begin
    cnt_nxt   = cnt_r;
    slots_nxt = slots_r;
    code_base = {5'(scan_idx_r) - 5'd1, 3'b000};
    for (int b = 0; b < 8; b++) begin
      if (rd_byte[b]) begin
        if (cnt_nxt < CNT_W'(BOOT_KEY_SLOTS)) begin
          slots_nxt[cnt_nxt[SL_W-1:0]] = code_base | 8'(b);
        end
        if (cnt_nxt <= CNT_W'(BOOT_KEY_SLOTS)) cnt_nxt = cnt_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= BI_W'(1);
      cnt_r      <= '0;
    end else if (cmd.start) begin
      scan_idx_r <= BI_W'(1);
      cnt_r      <= '0;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int s = 0; s < int'(BOOT_KEY_SLOTS); s++) slots_r[s] <= '0;
    end else if (cmd.scan) begin
      slots_r <= slots_nxt;
    end
  end

  assign sts.scan_done = cmd.scan && (scan_idx_r == BI_W'(REPORT_BYTES - 1));

  // byte selection for the outgoing report
  assign overflow  = (cnt_r > CNT_W'(BOOT_KEY_SLOTS));
  assign slot_sel  = emit_idx_r - IDX_W'(2);
  assign slot_byte = overflow ? 8'd1 : slots_r[slot_sel[SL_W-1:0]];

  always_comb begin
    if (!cmd.boot) begin
      emit_byte = rd_byte;
      emit_last = (emit_idx_r == IDX_W'(REPORT_BYTES - 1));
    end else begin
      if (emit_idx_r == '0) emit_byte = rd_byte;
      else if (emit_idx_r == IDX_W'(1)) emit_byte = '0;
      else emit_byte = slot_byte;
      emit_last = (emit_idx_r == IDX_W'(BOOT_KEY_SLOTS + 1));
    end
  end

  assign load          = cmd.emit && (!out_valid_r || out_ready);
  assign sts.emit_done = load && emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.start) begin
      emit_idx_r <= '0;
    end else if (load) begin
      emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= emit_byte;
      out_idx_r  <= emit_idx_r;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_byte = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_last_byte   = out_last_r;

  `NKRO_ASSERT_IMP(a_last_at_end, clk, rst_n, out_valid_r && out_last_r, (out_idx_r == IDX_W'(REPORT_BYTES - 1)) || (out_idx_r == IDX_W'(BOOT_KEY_SLOTS + 1)), "last beat at wrong index")
  `NKRO_ASSERT_IMP(a_cnt_sat, clk, rst_n, 1'b1, cnt_r <= CNT_W'(BOOT_KEY_SLOTS + 1), "slot count beyond saturation")
  `NKRO_ASSERT_IMP(a_emit_range, clk, rst_n, cmd.emit && cmd.boot, emit_idx_r <= IDX_W'(BOOT_KEY_SLOTS + 1), "boot emit index past end")

endmodule

`default_nettype wire

// ----- sv/nkro_ctrl.sv -----
`default_nettype none
`include "nkro_keyboard_report_engine_macros.svh"

module nkro_ctrl
  import nkro_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OPC_W-1:0] in_opcode,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_report_protocol,
  output dp_cmd_t               cmd,
  input  wire dp_sts_t          sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  logic    changed_r;
  logic    changed_nxt;
  logic    proto_r;
  logic    accept;
  logic    send;
  opcode_t opc;

  assign opc       = opcode_t'(in_opcode);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.boot    = !proto_r;
    state_nxt   = state_r;
    changed_nxt = changed_r;
    send        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (opc)
            OP_KEY_DOWN: begin
              cmd.key_wr  = 1'b1;
              cmd.key_set = 1'b1;
              changed_nxt = 1'b1;
            end
            OP_KEY_UP: begin
              cmd.key_wr  = 1'b1;
              changed_nxt = 1'b1;
            end
            OP_RELEASE_ALL: begin
              cmd.clear_all = 1'b1;
              changed_nxt   = 1'b1;
            end
            OP_SEND: begin
              send = 1'b1;
            end
            OP_SEND_CHG: begin
              if (changed_r) begin
                send        = 1'b1;
                changed_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        if (send) begin
          cmd.start = 1'b1;
          state_nxt = proto_r ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_done) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      changed_r <= 1'b0;
      proto_r   <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      changed_r <= changed_nxt;
      if (cfg_valid && cfg_ready) proto_r <= cfg_report_protocol;
    end
  end

  `NKRO_ASSERT_IMP(a_no_edit_busy, clk, rst_n, state_r != S_IDLE, !cmd.key_wr && !cmd.clear_all, "bitmap edited during report")
  `NKRO_ASSERT_IMP(a_scan_done_in_scan, clk, rst_n, sts.scan_done, state_r == S_SCAN, "scan done outside scan")
  `NKRO_ASSERT_NXT(a_chg_clears, clk, rst_n, accept && (opc == OP_SEND_CHG) && changed_r, !changed_r && (state_r != S_IDLE), "conditional send did not clear flag")

endmodule

`default_nettype wire

// ----- sv/nkro_keyboard_report_engine.sv -----
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_opcode, in_keycode
// out     | output    | out_valid / out_ready  | out_report_byte, out_byte_index, out_last_byte
// cfg     | input     | cfg_valid / cfg_ready  | cfg_report_protocol
//
// key down, key up and release all leave in open, so the next beat is taken at once
// bitmap report: REPORT_BYTES bytes after the send beat, one byte per cycle through the
//   single bitmap read port unless out_ready stalls
// boot report: a scan of bitmap bytes 1 to REPORT_BYTES-1, one per cycle, then 2+BOOT_KEY_SLOTS bytes
// synchronous active-low reset clears bitmap and changed flag, selects bitmap report
// a stall on out holds the output register and the byte index, in stays closed until the last byte is loaded
`default_nettype none

module nkro_keyboard_report_engine
  import nkro_pkg::*;
#(
  parameter int unsigned REPORT_BYTES   = REPORT_BYTES_DEF,
  parameter int unsigned BOOT_KEY_SLOTS = BOOT_KEY_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item beats
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OPC_W-1:0]  in_opcode,
  input  wire logic [KEY_W-1:0]  in_keycode,
  // report beats
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_report_byte,
  output logic [IDX_W-1:0]       out_byte_index,
  output logic                   out_last_byte,
  // protocol select register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_report_protocol
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: opcode decode, changed flag, protocol register
  nkro_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_report_protocol (cfg_report_protocol),
    .cmd                 (cmd),
    .sts                 (sts)
  );

  // datapath: key bitmap, boot slot scan, output register
  nkro_dpath #(
    .REPORT_BYTES   (REPORT_BYTES),
    .BOOT_KEY_SLOTS (BOOT_KEY_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_keycode      (in_keycode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_report_byte (out_report_byte),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte)
  );

endmodule

`default_nettype wire
